[hw/rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and controller/datapath signal groups of the
// sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int VAL_W    = 32;

	localparam logic [1:0] OP_INSERT    = 2'd0;
	localparam logic [1:0] OP_REMOVE    = 2'd1;
	localparam logic [1:0] OP_DUMP_ASC  = 2'd2;
	localparam logic [1:0] OP_DUMP_DESC = 2'd3;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_REMOVED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_LISTED    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;       // apply an insert or remove and load its result
		logic dump_start; // latch direction and clear the dump step
		logic dump_emit;  // load the entry at the current step and advance
		logic empty_emit; // load the empty-list result
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic dump_last;
	} dp_status_t;

endpackage

[hw/rtl/sle_req_if.sv]
// ----------------------------------------------------------------------------
// sle_req_if
// Request channel: one operation item with its value.
// ----------------------------------------------------------------------------
interface sle_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        operation;
	logic signed [sle_pkg::VAL_W-1:0]  value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

[hw/rtl/sle_rsp_if.sv]
// ----------------------------------------------------------------------------
// sle_rsp_if
// Response channel: one result item per insert or remove, one per entry on
// a dump, and one empty-list item on a dump of an empty list.
// ----------------------------------------------------------------------------
interface sle_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [2:0]                        status;
	logic signed [sle_pkg::VAL_W-1:0]  entry_value;
	logic [4:0]                        entry_count;
	logic                              last;

	modport source (output valid, output status, output entry_value,
		output entry_count, output last, input ready);
	modport sink   (input valid, input status, input entry_value,
		input entry_count, input last, output ready);
endinterface

[hw/rtl/sle_datapath.sv]
// ----------------------------------------------------------------------------
// sle_datapath
// Row of compare-and-shift cells holding the sorted entries, the entry count,
// the dump step and the result register.
// ----------------------------------------------------------------------------
module sle_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sle_pkg::ctrl_cmd_t                cmd,
	input  logic [1:0]                        operation,
	input  logic signed [sle_pkg::VAL_W-1:0]  value,
	output sle_pkg::dp_status_t               stat,
	output logic [2:0]                        status,
	output logic signed [sle_pkg::VAL_W-1:0]  entry_value,
	output logic [4:0]                        entry_count,
	output logic                              last
);

	logic signed [sle_pkg::VAL_W-1:0] store_q [sle_pkg::CAPACITY];
	logic [sle_pkg::CNT_W-1:0]        count_q;
	logic [sle_pkg::IDX_W-1:0]        step_q;
	logic                             desc_q;

	sle_pkg::status_t                 status_q;
	logic signed [sle_pkg::VAL_W-1:0] value_q;
	logic [sle_pkg::CNT_W-1:0]        count_out_q;
	logic                             last_q;

	logic [sle_pkg::CAPACITY-1:0]     lt;
	logic [sle_pkg::CAPACITY-1:0]     eq;
	logic [sle_pkg::CAPACITY-1:0]     hit_before;
	logic                             any_eq;
	logic                             full;
	logic signed [sle_pkg::VAL_W-1:0] ins_next [sle_pkg::CAPACITY];
	logic signed [sle_pkg::VAL_W-1:0] rem_next [sle_pkg::CAPACITY];
	logic [sle_pkg::CNT_W-1:0]        count_m1;
	logic [sle_pkg::CNT_W-1:0]        rev_idx;
	logic [sle_pkg::IDX_W-1:0]        rd_idx;
	logic                             is_insert;

	assign full      = (count_q == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
	assign count_m1  = count_q - sle_pkg::CNT_W'(1);
	assign rev_idx   = count_m1 - sle_pkg::CNT_W'(step_q);
	assign rd_idx    = desc_q ? rev_idx[sle_pkg::IDX_W-1:0] : step_q;
	assign is_insert = (operation == sle_pkg::OP_INSERT);

	// Each cell compares its own entry with the incoming value; only cells
	// below the count take part.
	always_comb begin
		for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
			lt[i] = (sle_pkg::CNT_W'(i) < count_q) && (store_q[i] < value);
			eq[i] = (sle_pkg::CNT_W'(i) < count_q) && (store_q[i] == value);
		end
		hit_before[0] = 1'b0;
		for (int i = 1; i < sle_pkg::CAPACITY; i++) begin
			hit_before[i] = hit_before[i-1] | eq[i-1];
		end
		any_eq = hit_before[sle_pkg::CAPACITY-1] | eq[sle_pkg::CAPACITY-1];
	end

	// Insert: cells holding smaller entries keep them, the first cell that is
	// not smaller takes the value, and the cells above take their neighbour's.
	always_comb begin
		ins_next[0] = lt[0] ? store_q[0] : value;
		for (int i = 1; i < sle_pkg::CAPACITY; i++) begin
			if (lt[i]) begin
				ins_next[i] = store_q[i];
			end else if (lt[i-1]) begin
				ins_next[i] = value;
			end else begin
				ins_next[i] = store_q[i-1];
			end
		end
	end

	// Remove: from the first equal entry upwards every cell takes the entry
	// of the cell above.
	always_comb begin
		for (int i = 0; i < sle_pkg::CAPACITY - 1; i++) begin
			rem_next[i] = (hit_before[i] | eq[i]) ? store_q[i+1] : store_q[i];
		end
		rem_next[sle_pkg::CAPACITY-1] = store_q[sle_pkg::CAPACITY-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (is_insert && !full) begin
				count_q <= count_q + sle_pkg::CNT_W'(1);
			end else if (!is_insert && any_eq) begin
				count_q <= count_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_insert && !full) begin
				store_q <= ins_next;
			end else if (!is_insert && any_eq) begin
				store_q <= rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dump_start) begin
			desc_q <= (operation == sle_pkg::OP_DUMP_DESC);
			step_q <= '0;
		end else if (cmd.dump_emit) begin
			step_q <= step_q + sle_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			value_q <= value;
			last_q  <= 1'b1;
			if (is_insert) begin
				status_q    <= full ? sle_pkg::ST_FULL : sle_pkg::ST_INSERTED;
				count_out_q <= full ? count_q : count_q + sle_pkg::CNT_W'(1);
			end else begin
				status_q    <= any_eq ? sle_pkg::ST_REMOVED : sle_pkg::ST_NOT_FOUND;
				count_out_q <= any_eq ? count_m1 : count_q;
			end
		end else if (cmd.empty_emit) begin
			status_q    <= sle_pkg::ST_EMPTY;
			value_q     <= '0;
			count_out_q <= '0;
			last_q      <= 1'b1;
		end else if (cmd.dump_emit) begin
			status_q    <= sle_pkg::ST_LISTED;
			value_q     <= store_q[rd_idx];
			count_out_q <= count_q;
			last_q      <= stat.dump_last;
		end
	end

	assign stat.count_zero = (count_q == '0);
	assign stat.dump_last  = (sle_pkg::CNT_W'(step_q) == count_m1);

	assign status      = status_q;
	assign entry_value = value_q;
	assign entry_count = 5'(count_out_q);
	assign last        = last_q;

endmodule

[hw/rtl/sle_ctrl.sv]
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller: accepts request items, sequences dumps and owns the valid flag
// of the result register.
// ----------------------------------------------------------------------------
module sle_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           operation,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  sle_pkg::dp_status_t  stat,
	output sle_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;
	logic   accept;
	logic   is_dump;

	// The result register is free when empty or being taken this cycle.
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign is_dump   = (operation == sle_pkg::OP_DUMP_ASC) ||
		(operation == sle_pkg::OP_DUMP_DESC);
	assign req_ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!is_dump) begin
						cmd.exec = 1'b1;
					end else if (stat.count_zero) begin
						cmd.empty_emit = 1'b1;
					end else begin
						cmd.dump_start = 1'b1;
						state_d        = S_DUMP;
					end
				end
			end
			S_DUMP: begin
				if (slot_free) begin
					cmd.dump_emit = 1'b1;
					if (stat.dump_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec || cmd.empty_emit || cmd.dump_emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[hw/rtl/sorted_list_engine.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded ascending sorted multiset of signed 32-bit values with insert,
// remove and ascending or descending dump.
//
//   Channel  Direction  Payload
//   req      sink       operation[1:0], value[31:0] signed
//   rsp      source     status[2:0], entry_value[31:0] signed,
//                       entry_count[4:0], last
//
// Insert and remove complete in the cell row in the cycle the item is taken;
// the result is in the output register on the next cycle.
// A dump of n entries holds the controller in S_DUMP, listing all n after the item is
// taken, one listed entry per cycle while rsp is ready; an empty dump gives one.
// A stalled rsp holds the output register and stops requests and dump steps.
// Reset clears the entry count; the entries need no clearing.
// ----------------------------------------------------------------------------
module sorted_list_engine (
	input  logic      clk,
	input  logic      arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);

	sle_pkg::ctrl_cmd_t  cmd;
	sle_pkg::dp_status_t stat;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.operation (req.operation),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sle_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (req.operation),
		.value       (req.value),
		.stat        (stat),
		.status      (rsp.status),
		.entry_value (rsp.entry_value),
		.entry_count (rsp.entry_count),
		.last        (rsp.last)
	);

endmodule

[tb/sv/sorted_list_engine_test.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine_test
// Self-checking testbench of the sorted list engine. A driver offers request
// items in bursts from a queue that is filled up front. A shadow copy of the
// sorted list predicts every response item as each request is taken, and the
// monitor compares each response taken with the oldest prediction waiting.
// ----------------------------------------------------------------------------
module sorted_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sle_pkg::*;

	typedef struct {
		logic [1:0]              operation;
		logic signed [VAL_W-1:0] value;
		bit                      wait_idle; // hold back until every response is in
	} list_request_t;

	typedef struct {
		status_t                 status;
		logic signed [VAL_W-1:0] entry_value;
		logic [CNT_W-1:0]        entry_count;
		logic                    last;
	} list_response_t;

	logic clk;
	logic arst_n = 1'b0;

	sle_req_if req_ch ();
	sle_rsp_if rsp_ch ();

	sorted_list_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_request_t           pending_requests[$];
	list_response_t          due_responses[$];
	logic signed [VAL_W-1:0] shadow_list[CAPACITY];
	int unsigned             shadow_len    = 0;
	int unsigned             error_count   = 0;
	int unsigned             requests_taken = 0;
	bit                      req_taken     = 1'b0;
	int unsigned             burst_left    = 8;
	int unsigned             gap_left      = 0;
	int unsigned             hold_left     = 0;
	int unsigned             next_hold_at  = 50;
	int unsigned             holds_done    = 0;
	int unsigned             ready_mode    = 0;
	int unsigned             mode_left     = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic list_response_t make_response(status_t status,
		logic signed [VAL_W-1:0] entry_value, int unsigned count, logic last);
		list_response_t r;
		r.status      = status;
		r.entry_value = entry_value;
		r.entry_count = count[CNT_W-1:0];
		r.last        = last;
		return r;
	endfunction

	// Applies one request to the shadow list and queues the responses it causes.
	task automatic predict_list_op(logic [1:0] op, logic signed [VAL_W-1:0] v);
		int unsigned pos;
		int unsigned i;
		pos = 0;
		case (op)
			OP_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					due_responses.push_back(make_response(ST_FULL, v, shadow_len, 1'b1));
				end else begin
					// A new value goes before any equal ones already held: stop at the first not smaller.
					while (pos < shadow_len && shadow_list[pos] < v)
						pos++;
					for (i = shadow_len; i > pos; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[pos] = v;
					shadow_len++;
					due_responses.push_back(make_response(ST_INSERTED, v, shadow_len, 1'b1));
				end
			end
			OP_REMOVE: begin
				while (pos < shadow_len && shadow_list[pos] != v)
					pos++;
				if (pos >= shadow_len) begin
					due_responses.push_back(make_response(ST_NOT_FOUND, v, shadow_len, 1'b1));
				end else begin
					for (i = pos; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
					due_responses.push_back(make_response(ST_REMOVED, v, shadow_len, 1'b1));
				end
			end
			default: begin
				if (shadow_len == 0) begin
					due_responses.push_back(make_response(ST_EMPTY, '0, 0, 1'b1));
				end else begin
					for (i = 0; i < shadow_len; i++)
						due_responses.push_back(make_response(ST_LISTED,
							shadow_list[(op == OP_DUMP_ASC) ? i : shadow_len - 1 - i],
							shadow_len, i + 1 == shadow_len));
				end
			end
		endcase
	endtask

	function automatic void add_request(logic [1:0] op, logic signed [VAL_W-1:0] v,
		bit wait_idle);
		list_request_t r;
		r.operation = op;
		r.value     = v;
		r.wait_idle = wait_idle;
		pending_requests.push_back(r);
	endfunction

	// Small values give plenty of duplicates; the rest covers every bit.
	function automatic logic signed [VAL_W-1:0] random_value();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(0, 7))
			0, 1, 2: v = $signed($urandom_range(0, 8)) - 4;
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh7fff_ffff;
					1: v = 32'sh8000_0000;
					2: v = '0;
					default: v = -1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Request driver: bursts of items with gaps, changing on the falling edge.
	always @(negedge clk) begin : drive_requests
		list_request_t nxt;
		logic          nxt_valid;
		nxt_valid = req_ch.valid;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			req_taken = 1'b0;
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_requests.size() > 0 &&
				!(pending_requests[0].wait_idle && due_responses.size() != 0)) begin
				nxt = pending_requests.pop_front();
				nxt_valid = 1'b1;
				req_ch.operation <= nxt.operation;
				req_ch.value     <= nxt.value;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					case ($urandom_range(0, 3))
						0: begin
							gap_left = 0;
							burst_left = $urandom_range(1, 10);
						end
						1: begin
							gap_left = $urandom_range(1, 2);
							burst_left = $urandom_range(1, 10);
						end
						2: begin
							gap_left = $urandom_range(3, 8);
							burst_left = $urandom_range(1, 6);
						end
						default: begin
							gap_left = 0;
							burst_left = 30;
						end
					endcase
				end
			end
		end
		req_ch.valid <= nxt_valid;
	end

	// Response ready: a changing stall pattern, with long hold-offs now and then
	// so that the engine backs up and stops taking requests.
	always @(negedge clk) begin : drive_ready
		logic nxt_ready;
		if (!arst_n) begin
			nxt_ready = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			nxt_ready = 1'b0;
		end else if (holds_done < 2 && requests_taken >= next_hold_at) begin
			holds_done++;
			next_hold_at = 130;
			hold_left = 70;
			nxt_ready = 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 40);
			end
			mode_left--;
			case (ready_mode)
				0: nxt_ready = 1'b1;
				1: nxt_ready = $urandom_range(0, 1);
				2: nxt_ready = !rsp_ch.ready;
				default: nxt_ready = ($urandom_range(0, 9) != 0);
			endcase
		end
		rsp_ch.ready <= nxt_ready;
	end

	// Monitor: checks responses and predicts from requests taken at this edge.
	always @(posedge clk) begin : check_responses
		list_response_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_responses.size() == 0) begin
					error_count++;
					$display("%0t: unexpected response: status %0d value %0d count %0d last %0d",
						$realtime, rsp_ch.status, rsp_ch.entry_value,
						rsp_ch.entry_count, rsp_ch.last);
				end else begin
					want = due_responses.pop_front();
					if (rsp_ch.status !== want.status ||
						rsp_ch.entry_value !== want.entry_value ||
						rsp_ch.entry_count !== want.entry_count ||
						rsp_ch.last !== want.last) begin
						error_count++;
						$display({"%0t: mismatch: expected status %0d value %0d count %0d",
							" last %0d, got status %0d value %0d count %0d last %0d"},
							$realtime, want.status, want.entry_value, want.entry_count,
							want.last, rsp_ch.status, rsp_ch.entry_value,
							rsp_ch.entry_count, rsp_ch.last);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				predict_list_op(req_ch.operation, req_ch.value);
				requests_taken++;
				req_taken = 1'b1;
			end
		end
	end

	initial begin : run_test
		logic signed [VAL_W-1:0] live_values[$];
		logic signed [VAL_W-1:0] v;
		logic [1:0]              op;
		int unsigned             random_items;
		int unsigned             phase_len;
		int unsigned             kind;
		int unsigned             idx;
		int unsigned             n;
		bit                      first_phase;
		bit                      wait_flag;

		req_ch.valid     = 1'b0;
		req_ch.operation = OP_INSERT;
		req_ch.value     = '0;
		rsp_ch.ready     = 1'b0;

		// Directed: empty dumps, a miss on an empty list, extremes and duplicates.
		add_request(OP_DUMP_ASC, 32'sd9, 1'b0);
		add_request(OP_DUMP_DESC, -32'sd9, 1'b0);
		add_request(OP_REMOVE, 32'sd7, 1'b0);
		add_request(OP_INSERT, 32'sh7fff_ffff, 1'b0);
		add_request(OP_INSERT, 32'sh8000_0000, 1'b0);
		add_request(OP_INSERT, 32'sd0, 1'b0);
		add_request(OP_INSERT, -32'sd1, 1'b0);
		add_request(OP_INSERT, 32'sd5, 1'b0);
		add_request(OP_INSERT, 32'sd5, 1'b0);
		add_request(OP_INSERT, 32'sd1, 1'b0);
		add_request(OP_DUMP_ASC, 32'sh7fff_ffff, 1'b0);
		add_request(OP_DUMP_DESC, 32'sh8000_0000, 1'b0);
		add_request(OP_REMOVE, 32'sd5, 1'b0);
		add_request(OP_REMOVE, 32'sd1234, 1'b0);
		add_request(OP_REMOVE, 32'sh8000_0000, 1'b0);
		add_request(OP_REMOVE, 32'sh7fff_ffff, 1'b0);
		add_request(OP_DUMP_ASC, 32'sd0, 1'b0);
		add_request(OP_INSERT, 32'shaaaa_aaaa, 1'b0);
		add_request(OP_INSERT, 32'sh5555_5555, 1'b0);
		add_request(OP_DUMP_DESC, 32'sd0, 1'b0);
		live_values = '{32'sd0, -32'sd1, 32'sd5, 32'shaaaa_aaaa, 32'sh5555_5555};

		// Random phases: fills up to and past capacity, removals of values that
		// are mostly present, mixed operations and dumps.
		random_items = 0;
		first_phase = 1'b1;
		while (random_items < 140) begin
			kind = first_phase ? 0 : $urandom_range(0, 3);
			wait_flag = first_phase || ($urandom_range(0, 4) == 0);
			case (kind)
				0: phase_len = first_phase ? 18 : $urandom_range(8, 20);
				1: phase_len = $urandom_range(4, 12);
				2: phase_len = $urandom_range(5, 15);
				default: phase_len = 2;
			endcase
			for (n = 0; n < phase_len; n++) begin
				case (kind)
					0: op = OP_INSERT;
					1: op = OP_REMOVE;
					2: op = 2'($urandom_range(0, 3));
					default: op = (n == 0) ? OP_DUMP_ASC : OP_DUMP_DESC;
				endcase
				v = random_value();
				if (op == OP_REMOVE && live_values.size() > 0 &&
					$urandom_range(0, 9) < ((kind == 1) ? 8 : 5)) begin
					idx = $urandom_range(0, live_values.size() - 1);
					v = live_values[idx];
					live_values.delete(idx);
				end else if (op == OP_INSERT && live_values.size() < CAPACITY) begin
					live_values.push_back(v);
				end
				add_request(op, v, wait_flag && n == 0);
				random_items++;
			end
			if ($urandom_range(0, 1) == 1) begin
				add_request($urandom_range(0, 1) ? OP_DUMP_ASC : OP_DUMP_DESC, $urandom, 1'b0);
				random_items++;
			end
			first_phase = 1'b0;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_requests.size() == 0 && !req_ch.valid && due_responses.size() == 0);
		repeat (32) @(posedge clk);
		if (due_responses.size() != 0) begin
			error_count++;
			$display("%0t: %0d responses never arrived", $realtime, due_responses.size());
		end
		if (error_count == 0) begin
			$display("sorted_list_engine test passed");
		end else begin
			$display("sorted_list_engine test failed");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("sorted_list_engine test failed");
		$finish;
	end

endmodule
